FILE: rtl/shape_perimeter_area_assert.svh
// Assertion macros for the shape perimeter/area block.
// Define ASSERT_OFF to compile the checks out.
`ifndef SHAPE_PERIMETER_AREA_ASSERT_SVH
`define SHAPE_PERIMETER_AREA_ASSERT_SVH

`ifndef ASSERT_OFF
// Plain property check, sampled on the rising clock edge, off during reset.
`define SPA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("spa: check failed");
// Same-cycle implication check.
`define SPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spa: implication failed");
`else
`define SPA_ASSERT(label, clk, rst_n, prop)
`define SPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/spa_pkg.sv
`default_nettype none
package spa_pkg;

	localparam int DIM_W = 24;
	localparam int PER_W = 27;
	localparam int AREA_W = 50;
	localparam int ROOT_BITS = 51;
	localparam int RAD_W = 2 * ROOT_BITS;
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY = FRONT_STAGES + ROOT_BITS + 1;

	// pi = 3.14 in unsigned Q.16, truncated
	localparam logic [17:0] PI_Q16 = 18'd205783;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411566;

	// shape kinds; every other code is a triangle
	localparam logic [1:0] KIND_RECT = 2'd0;
	localparam logic [1:0] KIND_CIRC = 2'd1;

	// per-item results that ride alongside the root pipeline
	typedef struct packed {
		logic [PER_W-1:0]  per;
		logic [AREA_W-1:0] area;
		logic              bad;
		logic              is_tri;
	} spa_side_t;

endpackage
`default_nettype wire

FILE: rtl/shape_perimeter_area.sv
// Perimeter and area of one rectangle, circle or triangle per request. A request
// is taken on any cycle with start high; busy never rises, so one request a cycle
// is sustained. Each result appears on done for one cycle, after passing through
// the front stages of sums and split multiplies, the 51-stage square-root
// pipeline for Heron's area (one root bit per stage), and the output register.
// Results come out in request order and cannot be held off by the receiver.
`default_nettype none
module shape_perimeter_area (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 req_type,
	input  wire logic [spa_pkg::DIM_W-1:0]  dim_a,
	input  wire logic [spa_pkg::DIM_W-1:0]  dim_b,
	input  wire logic [spa_pkg::DIM_W-1:0]  dim_c,
	output logic                            done,
	output logic [spa_pkg::PER_W-1:0]       perimeter,
	output logic [spa_pkg::AREA_W-1:0]      area,
	output logic                            bad_triangle
);
	import spa_pkg::*;
	`include "shape_perimeter_area_assert.svh"

	logic                  valid_s4, root_valid;
	logic [RAD_W-1:0]      rad_s4;
	spa_side_t             side_s4, side_r;
	logic [ROOT_BITS-1:0]  root_r;

	assign busy = 1'b0;

	spa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.req_type (req_type),
		.dim_a    (dim_a),
		.dim_b    (dim_b),
		.dim_c    (dim_c),
		.valid_s4 (valid_s4),
		.rad_s4   (rad_s4),
		.side_s4  (side_s4)
	);

	spa_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.rad       (rad_s4),
		.side_in   (side_s4),
		.out_valid (root_valid),
		.root      (root_r),
		.side_out  (side_r)
	);

	// result register: triangle area is root/4, zero when impossible
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		perimeter <= side_r.per;
		bad_triangle <= side_r.bad;
		if (!side_r.is_tri) begin
			area <= side_r.area;
		end else if (side_r.bad) begin
			area <= '0;
		end else begin
			area <= AREA_W'(root_r >> 2);
		end
	end

	`SPA_ASSERT(a_fixed_latency, clk, arst_n, start |-> ##LATENCY done)
	`SPA_ASSERT_IMP(a_done_from_start, clk, arst_n, done, $past(start, LATENCY))
	`SPA_ASSERT_IMP(a_bad_zero_area, clk, arst_n, done && bad_triangle, area == '0)

endmodule
`default_nettype wire

FILE: rtl/spa_front.sv
`default_nettype none
module spa_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [1:0]                req_type,
	input  wire logic [spa_pkg::DIM_W-1:0] dim_a,
	input  wire logic [spa_pkg::DIM_W-1:0] dim_b,
	input  wire logic [spa_pkg::DIM_W-1:0] dim_c,
	output logic                           valid_s4,
	output logic [spa_pkg::RAD_W-1:0]      rad_s4,
	output spa_pkg::spa_side_t             side_s4
);
	import spa_pkg::*;

	// stage 1: sums, side checks, first products
	logic [25:0] sum_ab, sum_bc, sum_ac, ptri, d1, d2, d3;
	logic [23:0] mul_b;
	logic [42:0] cper_full;
	logic        is_rect, is_circ, is_tri;
	logic [PER_W-1:0] per_sel;

	assign is_rect = (req_type == KIND_RECT);
	assign is_circ = (req_type == KIND_CIRC);
	assign is_tri = !is_rect && !is_circ;
	assign sum_ab = 26'(dim_a) + 26'(dim_b);
	assign sum_bc = 26'(dim_b) + 26'(dim_c);
	assign sum_ac = 26'(dim_a) + 26'(dim_c);
	assign ptri = sum_ab + 26'(dim_c);
	// a negative difference shows in bit 25
	assign d1 = sum_bc - 26'(dim_a);
	assign d2 = sum_ac - 26'(dim_b);
	assign d3 = sum_ab - 26'(dim_c);
	assign mul_b = is_rect ? dim_b : dim_a;
	assign cper_full = 43'(TWO_PI_Q16) * 43'(dim_a);

	always_comb begin
		if (is_rect) begin
			per_sel = {sum_ab, 1'b0};
		end else if (is_circ) begin
			per_sel = cper_full[42:16];
		end else begin
			per_sel = PER_W'(ptri);
		end
	end

	logic              valid_s1, valid_s2, valid_s3;
	logic              is_tri_s1, is_circ_s1, bad_s1;
	logic [PER_W-1:0]  per_s1;
	logic [25:0]       ptri_s1;
	logic [24:0]       d1_s1, d2_s1, d3_s1;
	logic [47:0]       prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		is_tri_s1 <= is_tri;
		is_circ_s1 <= is_circ;
		bad_s1 <= is_tri && (d1[25] || d2[25] || d3[25]);
		per_s1 <= per_sel;
		ptri_s1 <= ptri;
		d1_s1 <= d1[24:0];
		d2_s1 <= d2[24:0];
		d3_s1 <= d3[24:0];
		prod_s1 <= 48'(dim_a) * 48'(mul_b);
	end

	// stage 2: Heron factors, circle area halves
	logic [50:0]       m1_s2;
	logic [49:0]       m2_s2;
	logic [AREA_W-1:0] ahi_s2;
	logic [17:0]       alo_s2;
	logic              is_tri_s2, bad_s2;
	logic [PER_W-1:0]  per_s2;
	logic [49:0]       chi;
	logic [33:0]       clo;

	assign chi = 50'(prod_s1[47:16]) * 50'(PI_Q16);
	assign clo = 34'(prod_s1[15:0]) * 34'(PI_Q16);

	always_ff @(posedge clk) begin
		m1_s2 <= 51'(ptri_s1) * 51'(d1_s1);
		m2_s2 <= 50'(d2_s1) * 50'(d3_s1);
		ahi_s2 <= is_circ_s1 ? chi : AREA_W'(prod_s1);
		alo_s2 <= is_circ_s1 ? clo[33:16] : 18'd0;
		is_tri_s2 <= is_tri_s1;
		bad_s2 <= bad_s1;
		per_s2 <= per_s1;
	end

	// stage 3: partial products of m1 * m2
	logic [50:0]       ll_s3, lh_s3;
	logic [49:0]       hl_s3, hh_s3;
	logic [AREA_W-1:0] area_s3;
	logic              is_tri_s3, bad_s3;
	logic [PER_W-1:0]  per_s3;

	always_ff @(posedge clk) begin
		ll_s3 <= 51'(m1_s2[25:0]) * 51'(m2_s2[24:0]);
		lh_s3 <= 51'(m1_s2[25:0]) * 51'(m2_s2[49:25]);
		hl_s3 <= 50'(m1_s2[50:26]) * 50'(m2_s2[24:0]);
		hh_s3 <= 50'(m1_s2[50:26]) * 50'(m2_s2[49:25]);
		area_s3 <= ahi_s2 + AREA_W'(alo_s2);
		is_tri_s3 <= is_tri_s2;
		bad_s3 <= bad_s2;
		per_s3 <= per_s2;
	end

	// stage 4: radicand F = 16 * area^2
	always_ff @(posedge clk) begin
		rad_s4 <= RAD_W'({hh_s3, 51'd0}) + RAD_W'({lh_s3, 25'd0})
			+ RAD_W'({hl_s3, 26'd0}) + RAD_W'(ll_s3);
		side_s4.per <= per_s3;
		side_s4.area <= area_s3;
		side_s4.bad <= bad_s3;
		side_s4.is_tri <= is_tri_s3;
	end

endmodule
`default_nettype wire

FILE: rtl/spa_isqrt.sv
`default_nettype none
module spa_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [spa_pkg::RAD_W-1:0]     rad,
	input  wire spa_pkg::spa_side_t            side_in,
	output logic                               out_valid,
	output logic [spa_pkg::ROOT_BITS-1:0]      root,
	output spa_pkg::spa_side_t                 side_out
);
	import spa_pkg::*;

	localparam int RB = ROOT_BITS;

	// one root bit per stage, most significant first
	logic              valid_s [RB];
	logic [RB-1:0]     rem_s   [RB];
	logic [RB-1:0]     root_s  [RB];
	logic [RAD_W-1:0]  rad_s   [RB];
	spa_side_t         side_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic              v_in;
		logic [RB-1:0]     rem_in, root_in;
		logic [RAD_W-1:0]  rad_in;
		spa_side_t         side_i;
		logic [RB+1:0]     cur, trial, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = '0;
			assign root_in = '0;
			assign rad_in = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in = rad_s[k-1];
			assign side_i = side_s[k-1];
		end

		// bring down the next bit pair, try root*4+1
		assign cur = {rem_in, rad_in[2*(RB-1-k)+1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign ge = (cur >= trial);
		assign diff = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[RB-1:0] : cur[RB-1:0];
			root_s[k] <= {root_in[RB-2:0], ge};
			rad_s[k] <= rad_in;
			side_s[k] <= side_i;
		end
	end

	assign out_valid = valid_s[RB-1];
	assign root = root_s[RB-1];
	assign side_out = side_s[RB-1];

endmodule
`default_nettype wire

FILE: test/tb_shape_perimeter_area.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_shape_perimeter_area;
	import spa_pkg::*;

	localparam logic [1:0] KIND_TRI = 2'd2;
	localparam logic [1:0] KIND_TRI_ALT = 2'd3;
	localparam logic [DIM_W-1:0] DMAX = '1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RAND_PER_PHASE = 375;

	typedef struct {
		logic [PER_W-1:0]  per;
		logic [AREA_W-1:0] area;
		logic              bad;
	} shape_res_t;

	typedef struct {
		logic [1:0]        kind;
		logic [DIM_W-1:0]  a, b, c;
		bit                typed;
		shape_res_t        res;
	} shape_row_t;

	logic clk, arst_n, start, busy, done, bad_triangle;
	logic [1:0] req_type;
	logic [DIM_W-1:0] dim_a, dim_b, dim_c;
	logic [PER_W-1:0] perimeter;
	logic [AREA_W-1:0] area;

	shape_res_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;

	shape_perimeter_area dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .dim_a(dim_a), .dim_b(dim_b), .dim_c(dim_c),
		.done(done), .perimeter(perimeter), .area(area), .bad_triangle(bad_triangle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// integer square root of a value up to 128 bits
	function automatic logic [63:0] isqrt128(input logic [127:0] v);
		logic [63:0] r, t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= v) r = t;
		end
		return r;
	endfunction

	// perimeter and area of one shape request
	function automatic shape_res_t shape_geometry(input logic [1:0] kind,
			input logic [DIM_W-1:0] a, b, c);
		shape_res_t r;
		logic [127:0] sa, sb, sc, p, f;
		sa = 128'(a);
		sb = 128'(b);
		sc = 128'(c);
		r.bad = 1'b0;
		if (kind == KIND_RECT) begin
			r.per = PER_W'(2 * (sa + sb));
			r.area = AREA_W'(sa * sb);
		end else if (kind == KIND_CIRC) begin
			r.per = PER_W'((2 * 128'(PI_Q16) * sa) >> 16);
			r.area = AREA_W'((sa * sa * 128'(PI_Q16)) >> 16);
		end else begin
			p = sa + sb + sc;
			r.per = PER_W'(p);
			if (sa > sb + sc || sb > sa + sc || sc > sa + sb) begin
				r.bad = 1'b1;
				r.area = '0;
			end else begin
				// Heron on raw Q.8 sides gives area * 2^16 after sqrt/4
				f = p * (sb + sc - sa) * (sa + sc - sb) * (sa + sb - sc);
				r.area = AREA_W'(isqrt128(f) >> 2);
			end
		end
		return r;
	endfunction

	// one request transfer; expectation is queued at the accepting edge
	task automatic send_shape(input shape_row_t row, input int idle_pct);
		shape_res_t exp_res;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= row.kind;
		dim_a <= row.a;
		dim_b <= row.b;
		dim_c <= row.c;
		@(posedge clk);
		while (busy) @(posedge clk);
		exp_res = row.typed ? row.res : shape_geometry(row.kind, row.a, row.b, row.c);
		expected_q.insert(expected_q.size(), exp_res);
	endtask

	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(3))
			0: return DIM_W'($urandom);
			1: return DIM_W'($urandom_range(4095));
			2: return DIM_W'($urandom_range(255));
			default: return DMAX - DIM_W'($urandom_range(255));
		endcase
	endfunction

	// random rows of any kind; most triangles get a third side that makes them valid
	function automatic shape_row_t rand_row();
		shape_row_t row;
		logic [DIM_W:0] lo, hi;
		row.typed = 1'b0;
		row.kind = 2'($urandom_range(3));
		row.a = rand_dim();
		row.b = rand_dim();
		row.c = rand_dim();
		if (row.kind[1] && $urandom_range(99) < 75) begin
			lo = (row.a > row.b) ? row.a - row.b : row.b - row.a;
			hi = {1'b0, row.a} + row.b;
			if (hi > DMAX) hi = DMAX;
			row.c = DIM_W'(lo + ({1'b0, $urandom} % (hi - lo + 1)));
		end
		return row;
	endfunction

	// result check and watchdog
	always @(posedge clk) begin
		shape_res_t e;
		if (arst_n) begin
			if (done) begin
				idle_cycles <= 0;
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: per=%h area=%h bad=%b",
						$time, perimeter, area, bad_triangle);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (perimeter !== e.per) begin
						$display("%0t: perimeter expected %h actual %h", $time, e.per, perimeter);
						errors++;
					end
					if (area !== e.area) begin
						$display("%0t: area expected %h actual %h", $time, e.area, area);
						errors++;
					end
					if (bad_triangle !== e.bad) begin
						$display("%0t: bad_triangle expected %b actual %b",
							$time, e.bad, bad_triangle);
						errors++;
					end
				end
			end else if (start && !busy) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog timeout", $time);
					$display("** shape_perimeter_area: FAILED **");
					$finish;
				end
			end
		end
	end

	initial begin
		shape_row_t dir[$];
		int idle_pct[4];
		int wait_cycles;
		idle_pct = '{0, 79, 0, 28};
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		dim_a = '0;
		dim_b = '0;
		dim_c = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: known answers typed in, others predicted
		dir = '{
			'{KIND_RECT, 24'd0, 24'd0, DMAX, 1'b1, '{27'd0, 50'd0, 1'b0}},
			'{KIND_RECT, DMAX, DMAX, 24'd0, 1'b1,
				'{27'h3FFFFFC, 50'hFFFFFE000001, 1'b0}},
			'{KIND_RECT, 24'h000100, 24'h000300, 24'h5A5A5A, 1'b0, '{0, 0, 0}},
			'{KIND_CIRC, 24'd0, DMAX, DMAX, 1'b1, '{27'd0, 50'd0, 1'b0}},
			'{KIND_CIRC, DMAX, 24'd0, 24'd0, 1'b0, '{0, 0, 0}},
			'{KIND_CIRC, 24'h000100, 24'h123456, 24'h654321, 1'b0, '{0, 0, 0}},
			'{KIND_TRI, 24'd100, 24'd1, 24'd1, 1'b1, '{27'd102, 50'd0, 1'b1}},
			'{KIND_TRI, 24'd1, 24'd100, 24'd1, 1'b1, '{27'd102, 50'd0, 1'b1}},
			'{KIND_TRI, 24'd1, 24'd1, 24'd100, 1'b1, '{27'd102, 50'd0, 1'b1}},
			'{KIND_TRI, 24'd5, 24'd3, 24'd2, 1'b1, '{27'd10, 50'd0, 1'b0}},
			'{KIND_TRI, 24'd0, 24'd7, 24'd7, 1'b1, '{27'd14, 50'd0, 1'b0}},
			'{KIND_TRI, 24'd0, 24'd0, 24'd0, 1'b1, '{27'd0, 50'd0, 1'b0}},
			'{KIND_TRI, DMAX, DMAX, DMAX, 1'b0, '{0, 0, 0}},
			'{KIND_TRI, 24'h000300, 24'h000400, 24'h000500, 1'b0, '{0, 0, 0}},
			'{KIND_TRI_ALT, 24'h000300, 24'h000400, 24'h000500, 1'b0, '{0, 0, 0}},
			'{KIND_TRI_ALT, DMAX, 24'd0, 24'd0, 1'b1, '{27'hFFFFFF, 50'd0, 1'b1}},
			'{KIND_TRI, DMAX, DMAX, 24'd1, 1'b0, '{0, 0, 0}}
		};
		foreach (dir[i]) send_shape(dir[i], 0);

		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// hold off new requests until the pipeline drains
				if (ph == 2 && n == RAND_PER_PHASE / 2) begin
					start <= 1'b0;
					@(posedge clk);
					while (expected_q.size() != 0) @(posedge clk);
				end
				send_shape(rand_row(), idle_pct[ph]);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (expected_q.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("** shape_perimeter_area: PASSED **");
		end else begin
			$display("** shape_perimeter_area: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
